>>> design/mbps_pkg.sv
package mbps_pkg;

  localparam int PATTERN_MAX_DEFAULT = 16;
  localparam int QUEUE_DEPTH         = 4;

  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 64;
  localparam int COUNT_W    = 10;
  localparam int LEN_W      = 5;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [COUNT_W-1:0] LIMIT_DEFAULT = 10'd500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT   = 3'd4;

  // one classified byte: an optional match and an optional end of scan summary
  typedef struct packed {
    logic               has_match;
    logic [ADDR_W-1:0]  match_address;
    logic [COUNT_W-1:0] match_count;
    logic               has_summary;
    logic [COUNT_W-1:0] summary_count;
  } mbps_rec_t;

endpackage

>>> design/mbps_front.sv
module mbps_front #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  logic [mbps_pkg::DATA_W-1:0]        data_byte,
  input  logic [mbps_pkg::ADDR_W-1:0]        byte_address,
  input  logic                               run_start,
  input  logic                               scan_end,
  output logic                               rec_valid,
  output mbps_pkg::mbps_rec_t                rec
);
  import mbps_pkg::*;

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int WIN_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

  logic [ADDR_W-1:0]  pattern_low;
  logic [ADDR_W-1:0]  pattern_high;
  logic [MASK_W-1:0]  care_mask;
  logic [LEN_W-1:0]   pattern_length;
  logic [COUNT_W-1:0] result_limit;

  logic [DATA_W-1:0]  byte_window [WIN_D];
  logic [FILL_W-1:0]  run_fill;
  logic [COUNT_W-1:0] hits_reported;

  logic [DATA_W-1:0]  pat [MASK_W];
  logic [DATA_W-1:0]  lane_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] lane_ok;
  logic [LEN_W-1:0]   len_eff;
  logic [FILL_W-1:0]  fill_base;
  logic [FILL_W-1:0]  fill_new;
  logic               window_hit;
  logic               is_match;
  logic [COUNT_W-1:0] hits_after;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pat[k]     = pattern_low[8*k +: 8];
      pat[k + 8] = pattern_high[8*k +: 8];
    end
  end

  assign len_eff = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : pattern_length;

  // lane a holds the byte seen a steps ago (lane 0 is the new byte)
  for (genvar a = 0; a < PATTERN_MAX; a++) begin : g_lane
    if (a == 0) begin : g_new
      assign lane_byte[a] = data_byte;
    end else begin : g_old
      assign lane_byte[a] = byte_window[a-1];
    end
  end

  // lane a lines up with pattern byte len-1-a
  always_comb begin
    logic [LEN_W-1:0] j;
    for (int a = 0; a < PATTERN_MAX; a++) begin
      j = LEN_W'(len_eff - 5'd1 - LEN_W'(a));
      lane_ok[a] = (LEN_W'(a) >= len_eff) || !care_mask[j[3:0]] ||
                   (lane_byte[a] == pat[j[3:0]]);
    end
  end

  assign window_hit = &lane_ok;
  assign fill_base  = run_start ? '0 : run_fill;
  assign fill_new   = (fill_base < FILL_W'(PATTERN_MAX)) ? fill_base + 1'b1 : fill_base;
  assign is_match   = (len_eff != '0) && (LEN_W'(fill_new) >= len_eff) &&
                      (hits_reported < result_limit) && window_hit;
  assign hits_after = is_match ? hits_reported + 1'b1 : hits_reported;

  assign rec_valid         = accept && (is_match || scan_end);
  assign rec.has_match     = is_match;
  assign rec.match_address = byte_address - (ADDR_W'(len_eff) - 64'd1);
  assign rec.match_count   = hits_after;
  assign rec.has_summary   = scan_end;
  assign rec.summary_count = hits_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '1;
      pattern_length <= 5'd1;
      result_limit   <= LIMIT_DEFAULT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_RESULT_LIMIT:   result_limit   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_fill      <= '0;
      hits_reported <= '0;
    end else if (accept) begin
      run_fill      <= scan_end ? '0 : fill_new;
      hits_reported <= scan_end ? '0 : hits_after;
    end
  end

  // stale bytes are never compared: the fill count gates every match
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_window[0] <= data_byte;
      for (int k = 1; k < WIN_D; k++) begin
        byte_window[k] <= byte_window[k-1];
      end
    end
  end

endmodule

>>> design/mbps_queue.sv
module mbps_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mbps_pkg::mbps_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output mbps_pkg::mbps_rec_t head,
  output logic                empty
);
  import mbps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mbps_rec_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

endmodule

>>> design/mbps_back.sv
module mbps_back (
  input  logic                            clk,
  input  logic                            rst,
  input  mbps_pkg::mbps_rec_t             head,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic [mbps_pkg::ADDR_W-1:0]     match_address,
  output logic                            is_summary,
  output logic [mbps_pkg::COUNT_W-1:0]    hit_count,
  output logic                            last_of_run
);
  import mbps_pkg::*;

  // set once the match of a two-result record has gone out
  logic phase;
  logic show_match;
  logic take;

  assign show_match    = head.has_match && !phase;
  assign take          = pop && !q_empty;
  assign empty         = q_empty;
  assign match_address = show_match ? head.match_address : '0;
  assign is_summary    = !show_match;
  assign hit_count     = show_match ? head.match_count : head.summary_count;
  assign last_of_run   = show_match ? !head.has_summary : 1'b1;
  assign q_pop         = take && !(show_match && head.has_summary);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= show_match && head.has_summary;
    end
  end

  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!q_empty && head.has_match && head.has_summary))
    else $error("summary phase without a two-result record at the head");

endmodule

>>> design/masked_byte_pattern_search_unit.sv
// Masked byte pattern search. Bytes enter one per cycle (push/full) with their
// address; run_start opens a new run and scan_end closes the scan. The newest
// bytes of the run are compared in parallel against a pattern of up to
// PATTERN_MAX bytes, with care_mask bits selecting which bytes must match.
// Each match yields one result transaction carrying the start address and the
// running hit count, until result_limit hits are reported; scan_end adds a
// summary transaction (is_summary = 1, address zero) after any match on the
// same byte. Rate: one byte per cycle, compare and hit accounting done in the
// cycle the byte is accepted. Results leave through a 4-record queue, one
// transaction per pop; a byte that both matches and ends the scan needs two
// pops. full rises only when that queue holds 4 records, so input stalls only
// when the result side falls behind. A result can be on the ports the cycle
// after its byte is accepted. Configuration (cfg_valid/cfg_ready, always ready)
// must be written only while the block is idle; writes act on the next byte.
module masked_byte_pattern_search_unit #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  // input byte stream
  input  logic                            push,
  output logic                            full,
  input  logic [mbps_pkg::DATA_W-1:0]     data_byte,
  input  logic [mbps_pkg::ADDR_W-1:0]     byte_address,
  input  logic                            run_start,
  input  logic                            scan_end,
  // result stream
  output logic                            empty,
  input  logic                            pop,
  output logic [mbps_pkg::ADDR_W-1:0]     match_address,
  output logic                            is_summary,
  output logic [mbps_pkg::COUNT_W-1:0]    hit_count,
  output logic                            last_of_run
);
  import mbps_pkg::*;

  logic      accept;
  logic      rec_valid;
  mbps_rec_t rec;
  mbps_rec_t head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  // front: window, fill and hit accounting, classifies each byte
  mbps_front #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .run_start    (run_start),
    .scan_end     (scan_end),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  // bytes that cause no result push nothing
  mbps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_valid),
    .push_rec (rec),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  // back: splits each record into one or two result transactions
  mbps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .match_address (match_address),
    .is_summary    (is_summary),
    .hit_count     (hit_count),
    .last_of_run   (last_of_run)
  );

endmodule

>>> tb/sv/mbps_search_checker.sv
// Watches the config, byte and result channels of the pattern search unit,
// predicts the result transactions of every accepted byte and compares them
// in order against the popped results.
module mbps_search_checker #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  input  logic                            full,
  input  logic [mbps_pkg::DATA_W-1:0]     data_byte,
  input  logic [mbps_pkg::ADDR_W-1:0]     byte_address,
  input  logic                            run_start,
  input  logic                            scan_end,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [mbps_pkg::ADDR_W-1:0]     match_address,
  input  logic                            is_summary,
  input  logic [mbps_pkg::COUNT_W-1:0]    hit_count,
  input  logic                            last_of_run,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  import mbps_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic               summary;
    logic [COUNT_W-1:0] count;
    logic               last;
  } report_t;

  report_t pending_reports[$];

  // register copies
  logic [2*CFG_DATA_W-1:0] pattern_bits;  // {pattern_high, pattern_low}
  logic [MASK_W-1:0]       care;
  logic [LEN_W-1:0]        pat_len;
  logic [COUNT_W-1:0]      limit;

  // run state, history[0] is the byte just before the newest one
  logic [DATA_W-1:0] history[PATTERN_MAX-1];
  int                fill;
  logic [COUNT_W-1:0] hits;

  task automatic clear_run();
    foreach (history[k]) history[k] = '0;
    fill = 0;
  endtask

  function automatic bit window_hit(input logic [DATA_W-1:0] newest, input int len);
    int                age;
    logic [DATA_W-1:0] b;
    for (int j = 0; j < len; j++) begin
      age = len - 1 - j;
      b   = (age == 0) ? newest : history[age-1];
      if (care[j] && b != pattern_bits[DATA_W*j +: DATA_W]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_reports();
    int      len;
    int      first;
    report_t rec;
    len   = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    first = pending_reports.size();
    if (run_start) clear_run();
    if (fill < PATTERN_MAX) fill++;
    if (len != 0 && fill >= len && hits < limit && window_hit(data_byte, len)) begin
      hits        = hits + 1'b1;
      rec.addr    = byte_address - ADDR_W'(len - 1);
      rec.summary = 1'b0;
      rec.count   = hits;
      rec.last    = 1'b0;
      pending_reports.insert(pending_reports.size(), rec);
    end
    for (int k = PATTERN_MAX - 2; k > 0; k--) history[k] = history[k-1];
    history[0] = data_byte;
    if (scan_end) begin
      rec.addr    = '0;
      rec.summary = 1'b1;
      rec.count   = hits;
      rec.last    = 1'b0;
      pending_reports.insert(pending_reports.size(), rec);
      hits = '0;
      clear_run();
    end
    if (pending_reports.size() > first)
      pending_reports[pending_reports.size()-1].last = 1'b1;
  endtask

  task automatic check_report();
    report_t got;
    report_t want;
    got = '{match_address, is_summary, hit_count, last_of_run};
    checked++;
    if (pending_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 20)
        $display("%0t: unexpected result addr %h summary %b count %0d last %b",
                 $time, got.addr, got.summary, got.count, got.last);
    end else begin
      want = pending_reports.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 20) begin
          $display("%0t: expected addr %h summary %b count %0d last %b",
                   $time, want.addr, want.summary, want.count, want.last);
          $display("%0t: actual   addr %h summary %b count %0d last %b",
                   $time, got.addr, got.summary, got.count, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pattern_bits = '0;
      care         = '1;
      pat_len      = LEN_W'(1);
      limit        = LIMIT_DEFAULT;
      hits         = '0;
      clear_run();
      pending_reports.delete();
    end else begin
      // results on the ports were caused by earlier bytes, so check first
      if (pop && !empty) check_report();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LOW:    pattern_bits[CFG_DATA_W-1:0] = cfg_data;
          REG_PATTERN_HIGH:   pattern_bits[2*CFG_DATA_W-1:CFG_DATA_W] = cfg_data;
          REG_CARE_MASK:      care = cfg_data[MASK_W-1:0];
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_RESULT_LIMIT:   limit = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) predict_reports();
    end
    pending = pending_reports.size();
  end

endmodule

>>> tb/sv/tb_masked_byte_pattern_search_unit.sv
// Top of the pattern search testbench: clock, reset, byte and config stimulus,
// result-side pop pattern, watchdog and verdict. All checking lives in the
// checker instance.
module tb_masked_byte_pattern_search_unit;
  import mbps_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction at all
  localparam int STALL_CYCLES = 80;    // long pop hold-off, fills the 4-deep queue
  localparam int SCAN_SETS    = 12;    // random register settings, 4 per idle pattern
  localparam int SET_BYTES    = 127;   // random bytes per setting

  // index with no register behind it; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  push;
  logic                  full;
  logic [DATA_W-1:0]     data_byte;
  logic [ADDR_W-1:0]     byte_address;
  logic                  run_start;
  logic                  scan_end;
  logic                  empty;
  logic                  pop;
  logic [ADDR_W-1:0]     match_address;
  logic                  is_summary;
  logic [COUNT_W-1:0]    hit_count;
  logic                  last_of_run;

  int fail_count;
  int pending;
  int checked;

  // idle percentages for the two sides, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  int stall_count;
  int bytes_sent;
  int quiet;

  // copy of the pattern in use, so random scans can embed it
  logic [2*CFG_DATA_W-1:0] gen_pattern;
  logic [MASK_W-1:0]       gen_care;
  int                      gen_len;
  logic [ADDR_W-1:0]       next_addr;

  always #(CLK_PERIOD/2) clk = ~clk;

  masked_byte_pattern_search_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .run_start    (run_start),
    .scan_end     (scan_end),
    .empty        (empty),
    .pop          (pop),
    .match_address(match_address),
    .is_summary   (is_summary),
    .hit_count    (hit_count),
    .last_of_run  (last_of_run)
  );

  mbps_search_checker u_search_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .run_start    (run_start),
    .scan_end     (scan_end),
    .empty        (empty),
    .pop          (pop),
    .match_address(match_address),
    .is_summary   (is_summary),
    .hit_count    (hit_count),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  // Watchdog: any accepted transaction on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side. A new stall request (stall_count bumped at a falling edge) is
  // picked up at the rising edge, then pop is held low for STALL_CYCLES while
  // the sender keeps pushing, so full must rise and hold the input.
  initial begin
    int hold;
    int stall_seen;
    hold       = 0;
    stall_seen = 0;
    pop        = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_count != stall_seen) begin
        stall_seen = stall_count;
        hold       = STALL_CYCLES;
      end
      @(negedge clk);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One byte transaction. Entered and left at a falling edge; push stays high
  // on exit so back-to-back bytes need no low cycle in between.
  task automatic send_byte(input logic [DATA_W-1:0] d, input logic [ADDR_W-1:0] a,
                           input logic s, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push         = 1'b1;
    data_byte    = d;
    byte_address = a;
    run_start    = s;
    scan_end     = e;
    do @(posedge clk); while (full);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every predicted result to be popped, then let bytes that produce
  // nothing, which may still be in flight, pass through before returning.
  task automatic settle();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                               input logic [MASK_W-1:0] c, input logic [LEN_W-1:0] n,
                               input logic [COUNT_W-1:0] lim);
    settle();
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, CFG_DATA_W'(c));
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(n));
    write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(lim));
    gen_pattern = {hi, lo};
    gen_care    = c;
    // zero length matches nothing; still embed one byte so the generator runs
    gen_len     = (n == 0) ? 1 : ((n > PATTERN_MAX_DEFAULT) ? PATTERN_MAX_DEFAULT : int'(n));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random scan traffic: mostly copies of the pattern (wildcards random, a few
  // corrupted bytes) over bytes biased toward pattern values, plus run breaks at
  // random points, scan ends every few dozen bytes and address jumps that wrap.
  task automatic scan_bytes(input int count);
    int                cursor;
    int                scan_left;
    logic [DATA_W-1:0] d;
    logic              s;
    logic              e;
    cursor    = -1;
    s         = 1'b1;
    scan_left = $urandom_range(150, 10);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 4) s = 1'b1;
      if (s) begin
        case ($urandom_range(3))
          0:       next_addr = ~ADDR_W'($urandom_range(20));  // wraps within the run
          1:       next_addr = ADDR_W'($urandom_range(255));
          default: next_addr = {$urandom, $urandom};
        endcase
      end
      if (cursor < 0 && $urandom_range(99) < 30) cursor = 0;
      if (cursor >= 0) begin
        if (gen_care[cursor] && $urandom_range(99) >= 5)
          d = gen_pattern[DATA_W*cursor +: DATA_W];
        else
          d = DATA_W'($urandom);
        cursor++;
        if (cursor >= gen_len) cursor = -1;
      end else if ($urandom_range(1)) begin
        d = gen_pattern[DATA_W*$urandom_range(PATTERN_MAX_DEFAULT-1) +: DATA_W];
      end else begin
        d = DATA_W'($urandom);
      end
      scan_left--;
      e = (scan_left == 0) || (i == count - 1);
      send_byte(d, next_addr, s, e);
      if (scan_left == 0) scan_left = $urandom_range(150, 10);
      next_addr++;
      s = 1'b0;
    end
  endtask

  initial begin
    logic [MASK_W-1:0]  c;
    logic [LEN_W-1:0]   n;
    logic [COUNT_W-1:0] lim;

    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    push          = 1'b0;
    data_byte     = '0;
    byte_address  = '0;
    run_start     = 1'b0;
    scan_end      = 1'b0;
    stall_count   = 0;
    bytes_sent    = 0;
    send_idle_pct = 37;
    recv_idle_pct = 46;
    gen_pattern   = '0;
    gen_care      = '1;
    gen_len       = 1;
    next_addr     = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values: one-byte pattern 0x00, every byte compared, limit 500.
    // Address extremes; the last byte both matches and ends the scan.
    send_byte(8'h00, '0, 1'b1, 1'b0);
    send_byte(8'hFF, '1, 1'b0, 1'b0);
    send_byte(8'h00, 64'h5555_5555_5555_5555, 1'b0, 1'b1);

    // Oversized length (31 acts as 16): full 16-byte pattern FF x8 then 00 x8,
    // with the byte addresses wrapping through zero so the start address does too.
    apply_setting('1, '0, 16'hFFFF, 5'd31, 10'd1023);
    for (int j = 0; j < 16; j++)
      send_byte((j < 8) ? 8'hFF : 8'h00, ~ADDR_W'(7) + ADDR_W'(j), j == 0, j == 15);

    // Zero length and all wildcards: nothing matches, the summary still comes.
    // Also a write to an index with no register.
    apply_setting('0, '1, 16'h0000, 5'd0, LIMIT_DEFAULT);
    write_reg(REG_SPARE, '1);
    send_byte(8'h00, 64'h10, 1'b1, 1'b0);
    send_byte(8'hFF, 64'h11, 1'b0, 1'b0);
    send_byte(8'hA5, 64'h12, 1'b0, 1'b1);

    // Length 4 with wildcards in bytes 1 and 3 (care bits above 4 unused).
    // Two matches but a limit of one: the second is dropped, summary says 1.
    apply_setting('1, '0, 16'hFFF5, 5'd4, 10'd1);
    send_byte(8'hFF, 64'h100, 1'b1, 1'b0);
    send_byte(8'h00, 64'h101, 1'b0, 1'b0);
    send_byte(8'hFF, 64'h102, 1'b0, 1'b0);
    send_byte(8'h00, 64'h103, 1'b0, 1'b0);
    send_byte(8'hFF, 64'h104, 1'b0, 1'b0);
    send_byte(8'hFF, 64'h105, 1'b0, 1'b1);

    // Random part: three idle patterns, four register settings each.
    for (int s = 0; s < SCAN_SETS; s++) begin
      case (s / (SCAN_SETS / 3))
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      case ($urandom_range(7))
        0, 1, 2, 3: c = '1;
        4, 5:       c = MASK_W'($urandom | $urandom);
        6:          c = MASK_W'($urandom);
        default:    c = '0;
      endcase

      case ($urandom_range(9))
        0:       n = LEN_W'($urandom_range(31, 17));
        1, 2:    n = LEN_W'($urandom_range(16, 9));
        default: n = LEN_W'($urandom_range(8, 1));
      endcase
      if (s == 2) n = LEN_W'(16);
      if (s == 3) n = '0;

      case ($urandom_range(3))
        0:       lim = COUNT_W'($urandom_range(4, 1));
        1:       lim = LIMIT_DEFAULT;
        default: lim = COUNT_W'($urandom_range(1023, 1));
      endcase
      if (s == 0) lim = '0;
      if (s == 1) lim = '1;

      // stall settings: all wildcards and the top limit, so nearly every byte
      // yields a result and the queue is sure to fill during the hold-off
      if (s % 4 == 1) begin
        c   = '0;
        lim = '1;
      end

      apply_setting(pick_word(), pick_word(), c, n, lim);
      if ($urandom_range(3) == 0)
        write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(1)), pick_word());

      // one long pop hold-off per idle pattern
      if (s % 4 == 1) stall_count++;
      scan_bytes(SET_BYTES);
    end

    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d bytes over %0d register settings plus directed cases",
             bytes_sent, SCAN_SETS);
    $display("%0d results checked; each idle pattern had a %0d-cycle result stall",
             checked, STALL_CYCLES);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mbps_pkg.sv
design/mbps_front.sv
design/mbps_queue.sv
design/mbps_back.sv
design/masked_byte_pattern_search_unit.sv
tb/sv/mbps_search_checker.sv
tb/sv/tb_masked_byte_pattern_search_unit.sv
